// ===== design/xst_pkg.sv =====
`timescale 1ns / 1ps
// xst_pkg: types, codes and byte-level helpers for the xml tokenizer
// no dependencies
package xst_pkg;

  localparam int MAX_EV = 10;

  typedef enum logic [4:0] {
    M_BEFORE, M_TEXT, M_TAG_OPEN, M_TAG_SLASH, M_NAME, M_END_WS, M_ATTR_WS,
    M_SLASH_WS, M_QMARK, M_ANAME, M_ANAME_WS, M_AFTER_EQ, M_VALUE, M_COMMENT,
    M_CDATA, M_CDATA_CLOSE, M_HALT, M_DONE
  } mode_t;

  typedef enum logic [1:0] {DK_NONE, DK_BANG, DK_QUEST} decl_t;

  localparam logic [3:0] K_TEXT       = 4'd0;
  localparam logic [3:0] K_TEXT_END   = 4'd1;
  localparam logic [3:0] K_NAME       = 4'd2;
  localparam logic [3:0] K_NS_SPLIT   = 4'd3;
  localparam logic [3:0] K_TAG_START  = 4'd4;
  localparam logic [3:0] K_ANAME      = 4'd5;
  localparam logic [3:0] K_ANAME_END  = 4'd6;
  localparam logic [3:0] K_VALUE      = 4'd7;
  localparam logic [3:0] K_VALUE_END  = 4'd8;
  localparam logic [3:0] K_TAG_END    = 4'd9;
  localparam logic [3:0] K_COMMENT    = 4'd10;
  localparam logic [3:0] K_COMMENT_END = 4'd11;
  localparam logic [3:0] K_CDATA      = 4'd12;
  localparam logic [3:0] K_CDATA_END  = 4'd13;
  localparam logic [3:0] K_ERROR      = 4'd14;
  localparam logic [3:0] K_DONE       = 4'd15;

  localparam logic [7:0] E_NO_LT    = 8'd0;
  localparam logic [7:0] E_EOF      = 8'd1;
  localparam logic [7:0] E_NO_GT    = 8'd2;
  localparam logic [7:0] E_NO_EQ    = 8'd3;
  localparam logic [7:0] E_NO_QUOTE = 8'd4;
  localparam logic [7:0] E_NEST     = 8'd5;

  localparam logic [7:0] C_LT = 8'h3C, C_GT = 8'h3E, C_AMP = 8'h26, C_SEMI = 8'h3B;
  localparam logic [7:0] C_BANG = 8'h21, C_QUEST = 8'h3F, C_SLASH = 8'h2F;
  localparam logic [7:0] C_EQ = 8'h3D, C_DQ = 8'h22, C_SQ = 8'h27, C_COLON = 8'h3A;
  localparam logic [7:0] C_LBRK = 8'h5B, C_RBRK = 8'h5D, C_LPAR = 8'h28, C_RPAR = 8'h29;
  localparam logic [7:0] C_DASH = 8'h2D, C_HASH = 8'h23;

  localparam logic [2:0][7:0] PAT_COMMENT = 24'h2D2D21;
  localparam logic [7:0][7:0] PAT_CDATA = 64'h5B415441_44435B21;

  typedef struct packed {
    logic [MAX_EV-1:0][3:0] kind;
    logic [MAX_EV-1:0][7:0] data;
    logic [3:0]             cnt;
  } ev_bundle_t;

  typedef enum logic [1:0] {ER_FLUSH, ER_EMIT, ER_NONE} ent_act_t;

  typedef struct packed {
    ent_act_t   act;
    logic [7:0] val;
  } ent_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic ev_bundle_t push(input ev_bundle_t l, input logic [3:0] k,
                                      input logic [7:0] b);
    ev_bundle_t r;
    r = l;
    if (l.cnt < 4'(MAX_EV)) begin
      r.kind[l.cnt] = k;
      r.data[l.cnt] = b;
      r.cnt = l.cnt + 4'd1;
    end
    return r;
  endfunction

  function automatic logic hold_matches(input logic [7:0][7:0] h, input logic [3:0] n);
    logic mc, md;
    mc = (n <= 4'd3);
    md = (n <= 4'd8);
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        if (i < 3) begin
          if (h[i] != PAT_COMMENT[i]) mc = 1'b0;
        end else begin
          mc = 1'b0;
        end
        if (h[i] != PAT_CDATA[i]) md = 1'b0;
      end
    end
    return mc || md;
  endfunction

  function automatic ent_res_t resolve(input logic [5:0][7:0] e, input logic [2:0] n);
    ent_res_t r;
    logic [7:0] v;
    logic [11:0] t;
    logic go;
    r.act = ER_FLUSH;
    r.val = 8'd0;
    v = 8'd0;
    go = 1'b1;
    if (n == 3'd5 && e[0] == C_AMP && e[1] == 8'h61 && e[2] == 8'h6D && e[3] == 8'h70 &&
        e[4] == C_SEMI) begin
      r.act = ER_EMIT; r.val = C_AMP;
    end else if (n == 3'd4 && e[0] == C_AMP && e[1] == 8'h6C && e[2] == 8'h74 &&
                 e[3] == C_SEMI) begin
      r.act = ER_EMIT; r.val = C_LT;
    end else if (n == 3'd4 && e[0] == C_AMP && e[1] == 8'h67 && e[2] == 8'h74 &&
                 e[3] == C_SEMI) begin
      r.act = ER_EMIT; r.val = C_GT;
    end else if (n == 3'd6 && e[0] == C_AMP && e[1] == 8'h61 && e[2] == 8'h70 &&
                 e[3] == 8'h6F && e[4] == 8'h73 && e[5] == C_SEMI) begin
      r.act = ER_EMIT; r.val = C_SQ;
    end else if (n == 3'd6 && e[0] == C_AMP && e[1] == 8'h71 && e[2] == 8'h75 &&
                 e[3] == 8'h6F && e[4] == 8'h74 && e[5] == C_SEMI) begin
      r.act = ER_EMIT; r.val = C_DQ;
    end else if (n >= 3'd2 && e[1] == C_HASH) begin
      for (int i = 2; i < 6; i++) begin
        if (go && 3'(i) < n && e[i] >= 8'h30 && e[i] <= 8'h39) begin
          t = 12'(v) * 12'd10 + 12'(e[i] - 8'h30);
          v = (t > 12'd255) ? 8'd255 : t[7:0];
        end else begin
          go = 1'b0;
        end
      end
      r.act = (v != 8'd0) ? ER_EMIT : ER_NONE;
      r.val = v;
    end
    return r;
  endfunction

endpackage

// ===== design/xst_if.sv =====
`timescale 1ns / 1ps
// xst_byte_if and xst_event_if: valid/ready channels of the tokenizer
// no dependencies
interface xst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source(output valid, in_byte, end_of_input, input ready);
  modport sink(input valid, in_byte, end_of_input, output ready);
endinterface

interface xst_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [7:0] event_byte;
  logic       last_of_run;
  modport source(output valid, event_kind, event_byte, last_of_run, input ready);
  modport sink(input valid, event_kind, event_byte, last_of_run, output ready);
endinterface

// ===== design/xst_front.sv =====
`timescale 1ns / 1ps
// xst_front: parser state machine, turns one byte into a bundle of events
// depends on xst_pkg and xst_byte_if
module xst_front import xst_pkg::*; #(
  parameter int NEST_LIMIT = 255
) (
  input  logic          clk,
  input  logic          rst,
  xst_byte_if.sink      doc,
  input  logic          q_ready,
  output logic          q_push,
  output ev_bundle_t    q_data
);

  localparam int NW = $clog2(NEST_LIMIT + 1);

  mode_t            mode, mode_next;
  logic [7:0][7:0]  nh, nh_next;
  logic [3:0]       nhc, nhc_next;
  logic             colon, colon_next;
  logic [1:0]       obc, obc_next;
  logic             closing, closing_next;
  decl_t            dk, dk_next;
  logic [7:0]       vd, vd_next;
  logic [NW-1:0]    nd, nd_next;
  logic [5:0][7:0]  eh, eh_next;
  logic [2:0]       ec, ec_next;
  logic [1:0]       cc, cc_next;
  logic             ts, ts_next;
  logic             ns, ns_next;

  ev_bundle_t ev;
  logic       redo, done_ent, held, accept;
  logic [7:0] c, brk;
  logic [3:0] dkk;
  ent_res_t   er;

  assign c = doc.in_byte;
  assign doc.ready = q_ready;
  assign accept = doc.valid && q_ready;
  assign q_push = accept && ev.cnt != 4'd0;
  assign q_data = ev;

  always_comb begin
    mode_next = mode; nh_next = nh; nhc_next = nhc; colon_next = colon;
    obc_next = obc; closing_next = closing; dk_next = dk; vd_next = vd;
    nd_next = nd; eh_next = eh; ec_next = ec; cc_next = cc; ts_next = ts;
    ns_next = ns;
    ev = '0;
    redo = 1'b0;
    done_ent = 1'b0;
    held = 1'b0;
    brk = 8'd0;
    dkk = K_VALUE;
    er = '{act: ER_NONE, val: 8'd0};
    if (doc.end_of_input) begin
      if (mode != M_DONE) begin
        if (mode == M_TEXT) begin
          if (ec != 3'd0) ev = push(ev, K_ERROR, E_EOF);
        end else if (mode != M_BEFORE && mode != M_HALT) begin
          ev = push(ev, K_ERROR, E_EOF);
        end
        ev = push(ev, K_DONE, 8'd0);
        mode_next = M_DONE;
      end
    end else if (mode != M_HALT && mode != M_DONE) begin
      redo = 1'b1;
    end

    for (int p = 0; p < 4; p++) begin
      if (redo) begin
        redo = 1'b0;
        done_ent = 1'b0;
        dkk = (mode_next == M_TEXT) ? K_TEXT : K_VALUE;
        if ((mode_next == M_TEXT || mode_next == M_VALUE) && ec_next != 3'd0) begin
          brk = (mode_next == M_TEXT) ? C_LT : vd_next;
          if (c == brk || c == C_AMP) begin
            for (int i = 0; i < 6; i++) begin
              if (3'(i) < ec_next) begin
                ev = push(ev, dkk, eh_next[i]);
                if (mode_next == M_TEXT) ts_next = 1'b1;
              end
            end
            ec_next = 3'd0;
            if (c == C_AMP) begin
              eh_next[0] = C_AMP; ec_next = 3'd1; done_ent = 1'b1;
            end
          end else begin
            if (ec_next < 3'd6) begin
              eh_next[ec_next] = c;
              ec_next = ec_next + 3'd1;
            end
            if (c == C_SEMI || ec_next >= 3'd6) begin
              er = resolve(eh_next, ec_next);
              if (er.act == ER_EMIT) begin
                ev = push(ev, dkk, er.val);
                if (mode_next == M_TEXT) ts_next = 1'b1;
              end else if (er.act == ER_FLUSH) begin
                for (int i = 0; i < 6; i++) begin
                  if (3'(i) < ec_next) begin
                    ev = push(ev, dkk, eh_next[i]);
                    if (mode_next == M_TEXT) ts_next = 1'b1;
                  end
                end
              end
              ec_next = 3'd0;
            end
            done_ent = 1'b1;
          end
        end
        if (!done_ent) begin
          unique case (mode_next)
            M_BEFORE: begin
              if (!is_ws(c)) begin
                if (c == C_LT) begin
                  closing_next = 1'b0; dk_next = DK_NONE; mode_next = M_TAG_OPEN;
                end else begin
                  ev = push(ev, K_ERROR, E_NO_LT); mode_next = M_HALT;
                end
              end
            end
            M_TEXT: begin
              if (c == C_LT) begin
                if (ts_next) ev = push(ev, K_TEXT_END, 8'd0);
                ts_next = 1'b0;
                closing_next = 1'b0; dk_next = DK_NONE; mode_next = M_TAG_OPEN;
              end else if (c == C_AMP) begin
                eh_next[0] = C_AMP; ec_next = 3'd1;
              end else begin
                ev = push(ev, K_TEXT, c); ts_next = 1'b1;
              end
            end
            M_TAG_OPEN, M_TAG_SLASH: begin
              if (!is_ws(c)) begin
                if (mode_next == M_TAG_OPEN && c == C_SLASH) begin
                  closing_next = 1'b1; mode_next = M_TAG_SLASH;
                end else begin
                  if (mode_next == M_TAG_OPEN && c == C_BANG) dk_next = DK_BANG;
                  if (mode_next == M_TAG_OPEN && c == C_QUEST) dk_next = DK_QUEST;
                  nhc_next = 4'd0; ns_next = 1'b0; colon_next = 1'b0; obc_next = 2'd0;
                  mode_next = M_NAME; redo = 1'b1;
                end
              end
            end
            M_NAME: begin
              if (is_ws(c) || c == C_SLASH || c == C_GT) begin
                for (int i = 0; i < 8; i++)
                  if (4'(i) < nhc_next) ev = push(ev, K_NAME, nh_next[i]);
                nhc_next = 4'd0; ns_next = 1'b1;
                if (closing_next) mode_next = M_END_WS;
                else begin
                  ev = push(ev, K_TAG_START, 8'd0); mode_next = M_ATTR_WS;
                end
                redo = 1'b1;
              end else begin
                held = 1'b0;
                if (!ns_next) begin
                  if (nhc_next < 4'd8) begin
                    nh_next[nhc_next[2:0]] = c;
                    nhc_next = nhc_next + 4'd1;
                    if (hold_matches(nh_next, nhc_next)) held = 1'b1;
                    else nhc_next = nhc_next - 4'd1;
                  end
                  if (!held) begin
                    for (int i = 0; i < 8; i++)
                      if (4'(i) < nhc_next) ev = push(ev, K_NAME, nh_next[i]);
                    nhc_next = 4'd0; ns_next = 1'b1;
                  end
                end
                if (!held) begin
                  if (c == C_COLON && !colon_next) begin
                    colon_next = 1'b1; ev = push(ev, K_NS_SPLIT, 8'd0);
                  end else begin
                    ev = push(ev, K_NAME, c);
                  end
                end
                if (c == C_LBRK && obc_next != 2'd3) obc_next = obc_next + 2'd1;
                if (c == C_LBRK && obc_next >= 2'd2) begin
                  if (!ns_next && nhc_next == 4'd8) begin
                    nhc_next = 4'd0; mode_next = M_CDATA; cc_next = 2'd0; nd_next = '0;
                  end else begin
                    for (int i = 0; i < 8; i++)
                      if (4'(i) < nhc_next) ev = push(ev, K_NAME, nh_next[i]);
                    nhc_next = 4'd0; ns_next = 1'b1;
                    if (closing_next) mode_next = M_END_WS;
                    else begin
                      ev = push(ev, K_TAG_START, 8'd0); mode_next = M_ATTR_WS;
                    end
                  end
                end else if (!ns_next && nhc_next == 4'd3 && nh_next[1] == C_DASH) begin
                  nhc_next = 4'd0; mode_next = M_COMMENT; cc_next = 2'd0;
                end
              end
            end
            M_END_WS, M_SLASH_WS: begin
              if (!is_ws(c)) begin
                if (c == C_GT) begin
                  ev = push(ev, K_TAG_END, 8'd0);
                  mode_next = M_TEXT; ts_next = 1'b0; ec_next = 3'd0;
                end else begin
                  ev = push(ev, K_ERROR, E_NO_GT); mode_next = M_HALT;
                end
              end
            end
            M_ATTR_WS: begin
              if (!is_ws(c)) begin
                if (c == C_SLASH) begin
                  closing_next = 1'b1; mode_next = M_SLASH_WS;
                end else if (c == C_QUEST) begin
                  mode_next = M_QMARK;
                end else if (c == C_GT) begin
                  if (dk_next != DK_NONE) ev = push(ev, K_TAG_END, 8'd0);
                  mode_next = M_TEXT; ts_next = 1'b0; ec_next = 3'd0;
                end else if (dk_next == DK_BANG && (c == C_DQ || c == C_SQ ||
                             c == C_LBRK || c == C_LPAR)) begin
                  vd_next = c; nd_next = '0; ec_next = 3'd0; mode_next = M_VALUE;
                end else begin
                  mode_next = M_ANAME; redo = 1'b1;
                end
              end
            end
            M_QMARK: begin
              if (c == C_GT) begin
                if (dk_next != DK_NONE) ev = push(ev, K_TAG_END, 8'd0);
                mode_next = M_TEXT; ts_next = 1'b0; ec_next = 3'd0;
              end else begin
                ev = push(ev, K_ERROR, E_NO_GT); mode_next = M_HALT;
              end
            end
            M_ANAME: begin
              if (is_ws(c)) begin
                mode_next = M_ANAME_WS;
              end else if (dk_next != DK_NONE && c == C_GT) begin
                mode_next = M_ANAME_WS; redo = 1'b1;
              end else if (c == C_EQ) begin
                ev = push(ev, K_ANAME_END, 8'd0); mode_next = M_AFTER_EQ;
              end else begin
                ev = push(ev, K_ANAME, c);
              end
            end
            M_ANAME_WS: begin
              if (!is_ws(c)) begin
                if (dk_next != DK_NONE) begin
                  ev = push(ev, K_VALUE_END, 8'd0); mode_next = M_ATTR_WS; redo = 1'b1;
                end else if (c == C_EQ) begin
                  ev = push(ev, K_ANAME_END, 8'd0); mode_next = M_AFTER_EQ;
                end else begin
                  ev = push(ev, K_ERROR, E_NO_EQ); mode_next = M_HALT;
                end
              end
            end
            M_AFTER_EQ: begin
              if (!is_ws(c)) begin
                if (c == C_DQ || c == C_SQ) begin
                  vd_next = c; nd_next = '0; ec_next = 3'd0; mode_next = M_VALUE;
                end else begin
                  ev = push(ev, K_ERROR, E_NO_QUOTE); mode_next = M_HALT;
                end
              end
            end
            M_VALUE: begin
              if (dk_next == DK_BANG && ((vd_next == C_LBRK && c == C_RBRK) ||
                                         (vd_next == C_LPAR && c == C_RPAR))) begin
                if (nd_next != '0) begin
                  nd_next = nd_next - 1'b1; ev = push(ev, K_VALUE, c);
                end else begin
                  ev = push(ev, K_VALUE_END, 8'd0); mode_next = M_ATTR_WS;
                end
              end else if (c == vd_next) begin
                if (dk_next == DK_BANG && (vd_next == C_LBRK || vd_next == C_LPAR)) begin
                  if (nd_next >= NW'(NEST_LIMIT)) begin
                    ev = push(ev, K_ERROR, E_NEST); mode_next = M_HALT;
                  end else begin
                    nd_next = nd_next + 1'b1; ev = push(ev, K_VALUE, c);
                  end
                end else begin
                  ev = push(ev, K_VALUE_END, 8'd0); mode_next = M_ATTR_WS;
                end
              end else if (c == C_AMP) begin
                eh_next[0] = C_AMP; ec_next = 3'd1;
              end else begin
                ev = push(ev, K_VALUE, c);
              end
            end
            M_COMMENT: begin
              if (cc_next == 2'd0) begin
                if (c == C_DASH) cc_next = 2'd1;
                else ev = push(ev, K_COMMENT, c);
              end else if (cc_next == 2'd1) begin
                if (c == C_DASH) cc_next = 2'd2;
                else begin
                  ev = push(ev, K_COMMENT, C_DASH); ev = push(ev, K_COMMENT, c);
                  cc_next = 2'd0;
                end
              end else begin
                if (c == C_GT) begin
                  ev = push(ev, K_COMMENT_END, 8'd0); cc_next = 2'd0;
                  mode_next = M_TEXT; ts_next = 1'b0; ec_next = 3'd0;
                end else begin
                  ev = push(ev, K_COMMENT, C_DASH); ev = push(ev, K_COMMENT, C_DASH);
                  ev = push(ev, K_COMMENT, c); cc_next = 2'd0;
                end
              end
            end
            M_CDATA: begin
              if (cc_next == 2'd0) begin
                if (c == C_LBRK) begin
                  if (nd_next >= NW'(NEST_LIMIT)) begin
                    ev = push(ev, K_ERROR, E_NEST); mode_next = M_HALT;
                  end else begin
                    nd_next = nd_next + 1'b1; ev = push(ev, K_CDATA, c);
                  end
                end else if (c == C_RBRK) begin
                  if (nd_next == '0) cc_next = 2'd1;
                  else begin
                    nd_next = nd_next - 1'b1; ev = push(ev, K_CDATA, c);
                  end
                end else begin
                  ev = push(ev, K_CDATA, c);
                end
              end else begin
                cc_next = 2'd0;
                if (c == C_RBRK) begin
                  ev = push(ev, K_CDATA_END, 8'd0); mode_next = M_CDATA_CLOSE;
                end else begin
                  ev = push(ev, K_CDATA, C_RBRK); ev = push(ev, K_CDATA, c);
                end
              end
            end
            M_CDATA_CLOSE: begin
              if (!is_ws(c)) begin
                if (c == C_GT) begin
                  mode_next = M_TEXT; ts_next = 1'b0; ec_next = 3'd0;
                end else begin
                  ev = push(ev, K_ERROR, E_NO_GT); mode_next = M_HALT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_BEFORE; nhc <= 4'd0; colon <= 1'b0; obc <= 2'd0; closing <= 1'b0;
      dk <= DK_NONE; vd <= 8'd0; nd <= '0; ec <= 3'd0; cc <= 2'd0; ts <= 1'b0;
      ns <= 1'b0;
    end else if (accept) begin
      mode <= mode_next; nhc <= nhc_next; colon <= colon_next; obc <= obc_next;
      closing <= closing_next; dk <= dk_next; vd <= vd_next; nd <= nd_next;
      ec <= ec_next; cc <= cc_next; ts <= ts_next; ns <= ns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nh <= nh_next;
      eh <= eh_next;
    end
  end

endmodule

// ===== design/xst_queue.sv =====
`timescale 1ns / 1ps
// xst_queue: short fifo of event bundles between parser and serializer
// depends on xst_pkg
module xst_queue import xst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_en,
  input  ev_bundle_t push_data,
  output logic       not_full,
  input  logic       pop_en,
  output logic       not_empty,
  output ev_bundle_t head
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  ev_bundle_t      slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign not_full  = count != (AW+1)'(DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + 1'b1;
      if (pop_en) rd_ptr <= rd_ptr + 1'b1;
      if (push_en && !pop_en) count <= count + 1'b1;
      else if (pop_en && !push_en) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/xst_back.sv =====
`timescale 1ns / 1ps
// xst_back: serializes the head bundle one event per cycle onto the output while events.ready is high
// depends on xst_pkg and xst_event_if
module xst_back import xst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  ev_bundle_t  q_head,
  output logic        q_pop,
  xst_event_if.source events
);

  logic [3:0] idx;
  logic       last, fire;

  assign last = idx == q_head.cnt - 4'd1;
  assign fire = q_valid && events.ready;
  assign q_pop = fire && last;

  assign events.valid       = q_valid;
  assign events.event_kind  = q_head.kind[idx];
  assign events.event_byte  = q_head.data[idx];
  assign events.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (fire) begin
      idx <= last ? 4'd0 : idx + 4'd1;
    end
  end

endmodule

// ===== design/xml_sax_tokenizer.sv =====
`timescale 1ns / 1ps
// xml_sax_tokenizer: top level, parser front, bundle queue and event serializer
// depends on xst_pkg, xst_if, xst_front, xst_queue, xst_back
//
// usage
//   doc carries one document byte per request, or an end-of-input mark
//   events carries typed events; last_of_run flags the final event of a byte
//   the parser takes one byte per cycle while the bundle queue has room;
//   each byte yields 0 to 10 events, which leave one per cycle while events.ready is high
//   the events of a byte are written to the bundle queue when it is taken and leave from its head
//   throughput: one byte per cycle, bounded by one event per cycle on output
//   the four-entry bundle queue absorbs bursts; when it fills, doc.ready drops
//   a stalled receiver holds the current event steady until it is taken
//   reset clears the parser to the before-document state and empties the queue
//   bytes that give no event pass through without touching the queue
module xml_sax_tokenizer import xst_pkg::*; #(
  parameter int NEST_LIMIT = 255
) (
  input  logic        clk,
  input  logic        rst,
  xst_byte_if.sink    doc,
  xst_event_if.source events
);

  logic       q_ready, q_push, q_valid, q_pop;
  ev_bundle_t q_in, q_head;

  xst_front #(.NEST_LIMIT(NEST_LIMIT)) u_front (
    .clk(clk), .rst(rst), .doc(doc), .q_ready(q_ready), .q_push(q_push), .q_data(q_in)
  );

  xst_queue u_queue (
    .clk(clk), .rst(rst), .push_en(q_push), .push_data(q_in), .not_full(q_ready),
    .pop_en(q_pop), .not_empty(q_valid), .head(q_head)
  );

  xst_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .events(events)
  );

endmodule

// ===== tb/sv/xml_sax_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// xml_sax_tokenizer_tb: byte stream stimulus with a tokenizer model and event checks
// depends on xst_pkg, xst_if and xml_sax_tokenizer
module xml_sax_tokenizer_tb;
  import xst_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 170;

  typedef struct {
    logic [3:0] kind;
    logic [7:0] data;
    logic       last;
  } event_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         typed;
    logic [3:0] kind;
    logic [7:0] data;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  xst_byte_if  doc();
  xst_event_if events();

  xml_sax_tokenizer u_dut (
    .clk(clk),
    .rst(rst),
    .doc(doc),
    .events(events)
  );

  always #5 clk = ~clk;

  // parser state mirror
  mode_t      pmode;
  logic [7:0] name_buf[8];
  int         name_cnt;
  bit         colon_done;
  int         bracket_cnt;
  bit         closing;
  decl_t      dkind;
  logic [7:0] delim;
  int         depth;
  logic [7:0] ent_buf[6];
  int         ent_cnt;
  int         close_cnt;
  bit         text_any;
  bit         name_live;

  event_t     byte_events[$];
  event_t     pending_events[$];
  byte_row_t  rows[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         src_idle = 0;
  int         sink_stall = 0;

  bit         cur_typed;
  logic [3:0] cur_kind;
  logic [7:0] cur_data;

  function automatic bit space_byte(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic void emit(logic [3:0] k, logic [7:0] b);
    if (byte_events.size() < MAX_EV) byte_events.push_back('{k, b, 1'b0});
  endfunction

  function automatic void halt_on(logic [7:0] code);
    emit(K_ERROR, code);
    pmode = M_HALT;
  endfunction

  function automatic void enter_text();
    pmode = M_TEXT;
    text_any = 0;
    ent_cnt = 0;
  endfunction

  function automatic void emit_data(logic [7:0] b);
    if (pmode == M_TEXT) begin
      emit(K_TEXT, b);
      text_any = 1;
    end else begin
      emit(K_VALUE, b);
    end
  endfunction

  function automatic void ent_verbatim();
    for (int i = 0; i < ent_cnt && i < 6; i++) emit_data(ent_buf[i]);
    ent_cnt = 0;
  endfunction

  function automatic bit ent_is(string s);
    if (ent_cnt != s.len()) return 0;
    for (int i = 0; i < ent_cnt; i++) if (ent_buf[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void ent_decode();
    int v;
    int i;
    v = 0;
    if (ent_is("&amp;")) begin emit_data(C_AMP); ent_cnt = 0; return; end
    if (ent_is("&lt;")) begin emit_data(C_LT); ent_cnt = 0; return; end
    if (ent_is("&gt;")) begin emit_data(C_GT); ent_cnt = 0; return; end
    if (ent_is("&apos;")) begin emit_data(C_SQ); ent_cnt = 0; return; end
    if (ent_is("&quot;")) begin emit_data(C_DQ); ent_cnt = 0; return; end
    if (ent_cnt >= 2 && ent_buf[1] == C_HASH) begin
      i = 2;
      while (i < ent_cnt && ent_buf[i] >= 8'h30 && ent_buf[i] <= 8'h39) begin
        v = v * 10 + (ent_buf[i] - 8'h30);
        if (v > 255) v = 255;
        i++;
      end
      if (v != 0) emit_data(8'(v));
      ent_cnt = 0;
      return;
    end
    ent_verbatim();
  endfunction

  // 1 when the byte goes back to the enclosing mode
  function automatic bit ent_take(logic [7:0] c, logic [7:0] brk);
    if (c == brk) begin
      ent_verbatim();
      return 1;
    end
    if (c == C_AMP) begin
      ent_verbatim();
      ent_buf[0] = C_AMP;
      ent_cnt = 1;
      return 0;
    end
    if (ent_cnt < 6) begin
      ent_buf[ent_cnt] = c;
      ent_cnt++;
    end
    if (c == C_SEMI || ent_cnt >= 6) ent_decode();
    return 0;
  endfunction

  function automatic bit hold_is_prefix();
    string cm;
    string cd;
    bit ok;
    cm = "!--";
    cd = "![CDATA[";
    if (name_cnt <= 3) begin
      ok = 1;
      for (int i = 0; i < name_cnt; i++) if (name_buf[i] != cm[i]) ok = 0;
      if (ok) return 1;
    end
    if (name_cnt <= 8) begin
      ok = 1;
      for (int i = 0; i < name_cnt; i++) if (name_buf[i] != cd[i]) ok = 0;
      if (ok) return 1;
    end
    return 0;
  endfunction

  function automatic void name_release();
    for (int i = 0; i < name_cnt && i < 8; i++) emit(K_NAME, name_buf[i]);
    name_cnt = 0;
  endfunction

  function automatic void name_push(logic [7:0] c);
    if (!name_live) begin
      if (name_cnt < 8) begin
        name_buf[name_cnt] = c;
        name_cnt++;
        if (hold_is_prefix()) return;
        name_cnt--;
      end
      name_release();
      name_live = 1;
    end
    if (c == C_COLON && !colon_done) begin
      colon_done = 1;
      emit(K_NS_SPLIT, 8'd0);
    end else begin
      emit(K_NAME, c);
    end
  endfunction

  function automatic void name_close(bit again, logic [7:0] c);
    name_release();
    name_live = 1;
    if (closing) begin
      pmode = M_END_WS;
    end else begin
      emit(K_TAG_START, 8'd0);
      pmode = M_ATTR_WS;
    end
    if (again) parse_byte(c);
  endfunction

  function automatic void name_byte(logic [7:0] c);
    if (space_byte(c) || c == C_SLASH || c == C_GT) begin
      name_close(1, c);
      return;
    end
    name_push(c);
    if (c == C_LBRK) begin
      if (bracket_cnt < 3) bracket_cnt++;
      if (bracket_cnt >= 2) begin
        if (!name_live && name_cnt == 8) begin
          name_cnt = 0;
          pmode = M_CDATA;
          close_cnt = 0;
          depth = 0;
        end else begin
          name_close(0, 8'd0);
        end
        return;
      end
    end
    if (!name_live && name_cnt == 3 && name_buf[1] == C_DASH) begin
      name_cnt = 0;
      pmode = M_COMMENT;
      close_cnt = 0;
    end
  endfunction

  function automatic void name_begin(logic [7:0] c);
    name_cnt = 0;
    name_live = 0;
    colon_done = 0;
    bracket_cnt = 0;
    pmode = M_NAME;
    name_byte(c);
  endfunction

  function automatic void value_begin(logic [7:0] d);
    delim = d;
    depth = 0;
    ent_cnt = 0;
    pmode = M_VALUE;
  endfunction

  function automatic void value_byte(logic [7:0] c);
    bit bang;
    bang = dkind == DK_BANG;
    if (ent_cnt != 0 && !ent_take(c, delim)) return;
    if (bang && ((delim == C_LBRK && c == C_RBRK) || (delim == C_LPAR && c == C_RPAR))) begin
      if (depth > 0) begin
        depth--;
        emit(K_VALUE, c);
      end else begin
        emit(K_VALUE_END, 8'd0);
        pmode = M_ATTR_WS;
      end
    end else if (c == delim) begin
      if (bang && (delim == C_LBRK || delim == C_LPAR)) begin
        if (depth >= 255) begin
          halt_on(E_NEST);
          return;
        end
        depth++;
        emit(K_VALUE, c);
      end else begin
        emit(K_VALUE_END, 8'd0);
        pmode = M_ATTR_WS;
      end
    end else if (c == C_AMP) begin
      ent_buf[0] = C_AMP;
      ent_cnt = 1;
    end else begin
      emit(K_VALUE, c);
    end
  endfunction

  function automatic void open_tag();
    closing = 0;
    dkind = DK_NONE;
    pmode = M_TAG_OPEN;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    case (pmode)
      M_BEFORE: begin
        if (space_byte(c)) return;
        if (c == C_LT) open_tag();
        else halt_on(E_NO_LT);
      end
      M_TEXT: begin
        if (ent_cnt != 0 && !ent_take(c, C_LT)) return;
        if (c == C_LT) begin
          if (text_any) emit(K_TEXT_END, 8'd0);
          text_any = 0;
          open_tag();
        end else if (c == C_AMP) begin
          ent_buf[0] = C_AMP;
          ent_cnt = 1;
        end else begin
          emit_data(c);
        end
      end
      M_TAG_OPEN: begin
        if (space_byte(c)) return;
        if (c == C_BANG) dkind = DK_BANG;
        else if (c == C_QUEST) dkind = DK_QUEST;
        else if (c == C_SLASH) begin
          closing = 1;
          pmode = M_TAG_SLASH;
          return;
        end
        name_begin(c);
      end
      M_TAG_SLASH: if (!space_byte(c)) name_begin(c);
      M_NAME: name_byte(c);
      M_END_WS, M_SLASH_WS: begin
        if (space_byte(c)) return;
        if (c == C_GT) begin
          emit(K_TAG_END, 8'd0);
          enter_text();
        end else begin
          halt_on(E_NO_GT);
        end
      end
      M_ATTR_WS: begin
        if (space_byte(c)) return;
        if (c == C_SLASH) begin
          closing = 1;
          pmode = M_SLASH_WS;
        end else if (c == C_QUEST) begin
          pmode = M_QMARK;
        end else if (c == C_GT) begin
          if (dkind != DK_NONE) emit(K_TAG_END, 8'd0);
          enter_text();
        end else if (dkind == DK_BANG &&
                     (c == C_DQ || c == C_SQ || c == C_LBRK || c == C_LPAR)) begin
          value_begin(c);
        end else begin
          pmode = M_ANAME;
          parse_byte(c);
        end
      end
      M_QMARK: begin
        if (c == C_GT) begin
          if (dkind != DK_NONE) emit(K_TAG_END, 8'd0);
          enter_text();
        end else begin
          halt_on(E_NO_GT);
        end
      end
      M_ANAME: begin
        if (space_byte(c)) pmode = M_ANAME_WS;
        else if (dkind != DK_NONE && c == C_GT) begin
          pmode = M_ANAME_WS;
          parse_byte(c);
        end else if (c == C_EQ) begin
          emit(K_ANAME_END, 8'd0);
          pmode = M_AFTER_EQ;
        end else begin
          emit(K_ANAME, c);
        end
      end
      M_ANAME_WS: begin
        if (space_byte(c)) return;
        if (dkind != DK_NONE) begin
          emit(K_VALUE_END, 8'd0);
          pmode = M_ATTR_WS;
          parse_byte(c);
        end else if (c == C_EQ) begin
          emit(K_ANAME_END, 8'd0);
          pmode = M_AFTER_EQ;
        end else begin
          halt_on(E_NO_EQ);
        end
      end
      M_AFTER_EQ: begin
        if (space_byte(c)) return;
        if (c == C_DQ || c == C_SQ) value_begin(c);
        else halt_on(E_NO_QUOTE);
      end
      M_VALUE: value_byte(c);
      M_COMMENT: begin
        if (close_cnt == 0) begin
          if (c == C_DASH) close_cnt = 1;
          else emit(K_COMMENT, c);
        end else if (close_cnt == 1) begin
          if (c == C_DASH) close_cnt = 2;
          else begin
            emit(K_COMMENT, C_DASH);
            emit(K_COMMENT, c);
            close_cnt = 0;
          end
        end else begin
          if (c == C_GT) begin
            emit(K_COMMENT_END, 8'd0);
            close_cnt = 0;
            enter_text();
          end else begin
            emit(K_COMMENT, C_DASH);
            emit(K_COMMENT, C_DASH);
            emit(K_COMMENT, c);
            close_cnt = 0;
          end
        end
      end
      M_CDATA: begin
        if (close_cnt == 0) begin
          if (c == C_LBRK) begin
            if (depth >= 255) begin
              halt_on(E_NEST);
              return;
            end
            depth++;
            emit(K_CDATA, c);
          end else if (c == C_RBRK) begin
            if (depth == 0) close_cnt = 1;
            else begin
              depth--;
              emit(K_CDATA, c);
            end
          end else begin
            emit(K_CDATA, c);
          end
        end else begin
          close_cnt = 0;
          if (c == C_RBRK) begin
            emit(K_CDATA_END, 8'd0);
            pmode = M_CDATA_CLOSE;
          end else begin
            emit(K_CDATA, C_RBRK);
            emit(K_CDATA, c);
          end
        end
      end
      M_CDATA_CLOSE: begin
        if (space_byte(c)) return;
        if (c == C_GT) enter_text();
        else halt_on(E_NO_GT);
      end
      default: ;
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic eoi, bit typed,
                                        logic [3:0] k, logic [7:0] d);
    byte_events.delete();
    if (eoi) begin
      if (pmode != M_DONE) begin
        if (pmode == M_TEXT) begin
          if (ent_cnt != 0) emit(K_ERROR, E_EOF);
        end else if (pmode != M_BEFORE && pmode != M_HALT) begin
          emit(K_ERROR, E_EOF);
        end
        emit(K_DONE, 8'd0);
        pmode = M_DONE;
      end
    end else if (pmode != M_HALT && pmode != M_DONE) begin
      parse_byte(c);
    end
    if (typed) begin
      byte_events.delete();
      byte_events.push_back('{k, d, 1'b0});
    end
    if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last = 1'b1;
    foreach (byte_events[i]) pending_events.push_back(byte_events[i]);
  endfunction

  // stimulus building
  function automatic void add(logic [7:0] b);
    rows.push_back('{b, 1'b0, 1'b0, K_TEXT, 8'd0});
  endfunction

  function automatic void add_typed(logic [7:0] b, logic eoi, logic [3:0] k, logic [7:0] d);
    rows.push_back('{b, eoi, 1'b1, k, d});
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endfunction

  function automatic string rand_ws();
    string w;
    int j;
    w = " \t\n\r";
    j = $urandom_range(3);
    return w.substr(j, j);
  endfunction

  function automatic string rand_name();
    string letters;
    string s;
    int n;
    int j;
    letters = "abcxyz-.:Q";
    s = "";
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if (i == 0) j = $urandom_range(5);
      else j = $urandom_range(9);
      s = {s, letters.substr(j, j)};
    end
    return s;
  endfunction

  function automatic string rand_entity();
    case ($urandom_range(8))
      0: return "&amp;";
      1: return "&lt;";
      2: return "&gt;";
      3: return "&apos;";
      4: return "&quot;";
      5: return $sformatf("&#%0d;", $urandom_range(999));
      6: return "&#;";
      7: return "&zq;";
      default: return "&abcdefg";
    endcase
  endfunction

  function automatic void add_text();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == C_LT) b = 8'h00;
      add(b);
    end
  endfunction

  function automatic void add_value(logic [7:0] q);
    int n;
    logic [7:0] b;
    add(q);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) add_str(rand_entity());
      else begin
        b = 8'($urandom_range(255));
        if (b == q || b == C_AMP) b = 8'h41;
        add(b);
      end
    end
    add(q);
  endfunction

  function automatic void add_element();
    string nm;
    int na;
    nm = rand_name();
    add(C_LT);
    add_str(nm);
    na = $urandom_range(0, 2);
    for (int i = 0; i < na; i++) begin
      add_str(rand_ws());
      add_str(rand_name());
      if ($urandom_range(1)) add_str(rand_ws());
      add(C_EQ);
      if ($urandom_range(1)) add_str(rand_ws());
      add_value($urandom_range(1) ? C_DQ : C_SQ);
    end
    if ($urandom_range(1)) add_str(rand_ws());
    case ($urandom_range(3))
      0: add_str("/>");
      1: add_str("?>");
      default: begin
        add(C_GT);
        if ($urandom_range(1)) add_text();
        add_str("</");
        add_str(nm);
        if ($urandom_range(1)) add_str(rand_ws());
        add(C_GT);
      end
    endcase
  endfunction

  function automatic void add_comment();
    int n;
    add_str("<!--");
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_str("a");
        1: add_str("-b");
        2: add_str("--c");
        default: add_str(" >");
      endcase
    end
    add_str("-->");
  endfunction

  function automatic void add_cdata();
    int n;
    add_str("<![CDATA[");
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_str("x");
        1: add_str("[y]");
        2: add_str("]z");
        default: add_str("[[>]]");
      endcase
    end
    add_str("]]");
    if ($urandom_range(1)) add_str(rand_ws());
    add(C_GT);
  endfunction

  function automatic void add_decl();
    case ($urandom_range(3))
      0: add_str("<!DOCTYPE r [ <!x 'a'> (p(q)) ]>");
      1: add_str("<!ent\t\"v&lt;\" (a)>");
      2: add_str("<?xml v='1' b?>");
      default: add_str("<a[b[ >");
    endcase
  endfunction

  task automatic send(byte_row_t r);
    if ($urandom_range(99) < src_idle) begin
      doc.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    doc.valid <= 1'b1;
    doc.in_byte <= r.b;
    doc.end_of_input <= r.eoi;
    cur_typed <= r.typed;
    cur_kind <= r.kind;
    cur_data <= r.data;
    do @(posedge clk); while (!(doc.valid && doc.ready));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      events.ready <= 1'b0;
    end else begin
      events.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (events.valid && events.ready) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event kind %0d byte %0d", events.event_kind, events.event_byte);
          mismatches++;
        end else begin
          if (events.event_kind !== pending_events[0].kind) begin
            $error("event_kind expected %0d actual %0d", pending_events[0].kind,
                   events.event_kind);
            mismatches++;
          end
          if (events.event_byte !== pending_events[0].data) begin
            $error("event_byte expected %0d actual %0d", pending_events[0].data,
                   events.event_byte);
            mismatches++;
          end
          if (events.last_of_run !== pending_events[0].last) begin
            $error("last_of_run expected %0d actual %0d", pending_events[0].last,
                   events.last_of_run);
            mismatches++;
          end
          void'(pending_events.pop_front());
        end
      end
      if (doc.valid && doc.ready)
        tokenize_byte(doc.in_byte, doc.end_of_input, cur_typed, cur_kind, cur_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int head;
    int phase;
    doc.valid = 1'b0;
    doc.in_byte = 8'd0;
    doc.end_of_input = 1'b0;
    cur_typed = 1'b0;
    cur_kind = K_TEXT;
    cur_data = 8'd0;
    pmode = M_BEFORE;
    name_cnt = 0; colon_done = 0; bracket_cnt = 0; closing = 0; dkind = DK_NONE;
    delim = 8'd0; depth = 0; ent_cnt = 0; close_cnt = 0; text_any = 0; name_live = 0;

    // directed: leading whitespace, namespaced tag, entity in value, byte extremes
    add_str(" \t\r\n<p:q:r k=\"&lt;\">");
    add_typed(8'h00, 1'b0, K_TEXT, 8'h00);
    add_typed(8'hFF, 1'b0, K_TEXT, 8'hFF);
    add_str("&#300;");
    head = rows.size();

    while (rows.size() < head + RANDOM_BYTES) begin
      case ($urandom_range(9))
        0, 1: add_text();
        2: add_str(rand_entity());
        3, 4: add_element();
        5: add_comment();
        6: add_cdata();
        default: add_decl();
      endcase
    end

    // broken markup near the end, then end of input; a short tag and a second end of input follow
    case ($urandom_range(3))
      0: begin
        add_str("<a b ");
        add_typed("c", 1'b0, K_ERROR, E_NO_EQ);
        add_typed(8'h00, 1'b1, K_DONE, 8'd0);
      end
      1: begin
        add_str("<a b=");
        add_typed("x", 1'b0, K_ERROR, E_NO_QUOTE);
        add_typed(8'h00, 1'b1, K_DONE, 8'd0);
      end
      2: begin
        add_str("</a ");
        add_typed("x", 1'b0, K_ERROR, E_NO_GT);
        add_typed(8'h00, 1'b1, K_DONE, 8'd0);
      end
      default: begin
        add_str("<a");
        rows.push_back('{8'h00, 1'b1, 1'b0, K_TEXT, 8'd0});
      end
    endcase
    add_str("<x>");
    rows.push_back('{8'hFF, 1'b1, 1'b0, K_TEXT, 8'd0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < rows.size(); i++) begin
      phase = i * 4 / rows.size();
      src_idle = (phase == 1) ? 62 : (phase == 3) ? 19 : 0;
      sink_stall = (phase == 2) ? 62 : (phase == 3) ? 19 : 0;
      if (i == rows.size() / 2) begin
        doc.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
      end
      send(rows[i]);
    end
    doc.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/xst_pkg.sv
design/xst_if.sv
design/xst_front.sv
design/xst_queue.sv
design/xst_back.sv
design/xml_sax_tokenizer.sv
tb/sv/xml_sax_tokenizer_tb.sv
